// ===== rtl/suv_pkg.sv =====
// ----------------------------------------------------------------------------
// Streaming UTF-8 validator package
// Shared types, codes and decoding constants for the validator core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package suv_pkg;

    typedef enum logic [1:0] {
        MODE_DATA  = 2'd0,
        MODE_END   = 2'd1,
        MODE_BEGIN = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_ACTIVE = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_INVALID    = 3'd3,
        ST_INCOMPLETE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_INVALID = 2'd1,
        FAULT_LARGE   = 2'd2
    } fault_t;

    localparam int CP_W    = 21;
    localparam int MIN_W   = 17;
    localparam int FIELD_W = 32;

    localparam logic [FIELD_W-1:0] MAX_BYTES_RESET = 32'd67108864;

    localparam logic [7:0] ASCII_HIGH = 8'h7F;
    localparam logic [7:0] LEAD2_LOW  = 8'hC2;
    localparam logic [7:0] LEAD2_HIGH = 8'hDF;
    localparam logic [7:0] LEAD3_LOW  = 8'hE0;
    localparam logic [7:0] LEAD3_HIGH = 8'hEF;
    localparam logic [7:0] LEAD4_LOW  = 8'hF0;
    localparam logic [7:0] LEAD4_HIGH = 8'hF4;

    localparam logic [MIN_W-1:0] MIN2 = 17'h00080;
    localparam logic [MIN_W-1:0] MIN3 = 17'h00800;
    localparam logic [MIN_W-1:0] MIN4 = 17'h10000;

    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LOW  = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HIGH = 21'h00DFFF;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       last_in_chunk;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [FIELD_W-1:0] complete_length;
        logic [FIELD_W-1:0] total_length;
        logic [1:0]         pending_bytes;
    } result_t;

    // Outcome of decoding one byte against the partial character state.
    typedef struct packed {
        logic             err;
        logic             done;
        logic [1:0]       pending;
        logic [CP_W-1:0]  codepoint;
        logic [MIN_W-1:0] minimum;
    } dec_t;

endpackage

`default_nettype wire

// ===== rtl/suv_if.sv =====
// ----------------------------------------------------------------------------
// Streaming UTF-8 validator channels
// Valid/ready interfaces for the byte items, the results and the limit write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface suv_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last_in_chunk;

    modport source (output valid, output mode, output data_byte, output last_in_chunk,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input last_in_chunk,
                    output ready);
endinterface

interface suv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] complete_length;
    logic [31:0] total_length;
    logic [1:0]  pending_bytes;

    modport source (output valid, output status, output complete_length,
                    output total_length, output pending_bytes, input ready);
    modport sink   (input valid, input status, input complete_length,
                    input total_length, input pending_bytes, output ready);
endinterface

interface suv_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_stream_bytes;

    modport source (output valid, output max_stream_bytes, input ready);
    modport sink   (input valid, input max_stream_bytes, output ready);
endinterface

`default_nettype wire

// ===== rtl/suv_decode.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte decoder
// Advances the partial character state by one byte and flags broken input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module suv_decode (
    input  wire logic [1:0]               pending,
    input  wire logic [suv_pkg::CP_W-1:0]  codepoint,
    input  wire logic [suv_pkg::MIN_W-1:0] minimum,
    input  wire logic [7:0]               data_byte,
    output suv_pkg::dec_t                 dec
);

    logic [suv_pkg::CP_W-1:0] cp_shift;
    logic [1:0]               pend_dec;
    logic [suv_pkg::CP_W-1:0] min_ext;

    assign cp_shift = {codepoint[suv_pkg::CP_W-7:0], data_byte[5:0]};
    assign pend_dec = pending - 2'd1;
    assign min_ext  = {{(suv_pkg::CP_W-suv_pkg::MIN_W){1'b0}}, minimum};

    always_comb
    begin
        dec.err       = 1'b0;
        dec.done      = 1'b0;
        dec.pending   = pending;
        dec.codepoint = codepoint;
        dec.minimum   = minimum;

        if (pending == 2'd0)
        begin
            if (data_byte <= suv_pkg::ASCII_HIGH)
            begin
                dec.done = 1'b1;
            end
            else if (data_byte inside {[suv_pkg::LEAD2_LOW:suv_pkg::LEAD2_HIGH]})
            begin
                dec.pending   = 2'd1;
                dec.codepoint = {16'd0, data_byte[4:0]};
                dec.minimum   = suv_pkg::MIN2;
            end
            else if (data_byte inside {[suv_pkg::LEAD3_LOW:suv_pkg::LEAD3_HIGH]})
            begin
                dec.pending   = 2'd2;
                dec.codepoint = {17'd0, data_byte[3:0]};
                dec.minimum   = suv_pkg::MIN3;
            end
            else if (data_byte inside {[suv_pkg::LEAD4_LOW:suv_pkg::LEAD4_HIGH]})
            begin
                dec.pending   = 2'd3;
                dec.codepoint = {18'd0, data_byte[2:0]};
                dec.minimum   = suv_pkg::MIN4;
            end
            else
            begin
                dec.err = 1'b1;
            end
        end
        else if (data_byte[7:6] != 2'b10)
        begin
            dec.err = 1'b1;
        end
        else
        begin
            dec.codepoint = cp_shift;
            dec.pending   = pend_dec;
            // The last continuation byte completes the character: check its range.
            if (pend_dec == 2'd0)
            begin
                if (cp_shift < min_ext || cp_shift > suv_pkg::CP_MAX ||
                    (cp_shift >= suv_pkg::SURR_LOW && cp_shift <= suv_pkg::SURR_HIGH))
                begin
                    dec.err = 1'b1;
                end
                else
                begin
                    dec.done = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/suv_stream.sv =====
// ----------------------------------------------------------------------------
// Stream state tracker
// Holds the committed and in-chunk stream state and forms the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module suv_stream #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire suv_pkg::item_t               item,
    input  wire logic [suv_pkg::FIELD_W-1:0]  max_stream_bytes,
    output logic                              res_valid,
    output suv_pkg::result_t                  res
);

    localparam int CMP_W = (LENGTH_BITS > suv_pkg::FIELD_W) ? LENGTH_BITS : suv_pkg::FIELD_W;

    logic                       open_reg, open_next;
    logic [1:0]                 saved_pending_reg, saved_pending_next;
    logic [suv_pkg::CP_W-1:0]   saved_cp_reg, saved_cp_next;
    logic [suv_pkg::MIN_W-1:0]  saved_min_reg, saved_min_next;
    logic [LENGTH_BITS-1:0]     saved_complete_reg, saved_complete_next;
    logic [LENGTH_BITS-1:0]     saved_total_reg, saved_total_next;
    logic [1:0]                 work_pending_reg, work_pending_next;
    logic [suv_pkg::CP_W-1:0]   work_cp_reg, work_cp_next;
    logic [suv_pkg::MIN_W-1:0]  work_min_reg, work_min_next;
    logic [LENGTH_BITS-1:0]     work_complete_reg, work_complete_next;
    logic [LENGTH_BITS-1:0]     work_total_reg, work_total_next;
    suv_pkg::fault_t            fault_reg, fault_next;

    logic [1:0]                 w_pending;
    logic [suv_pkg::CP_W-1:0]   w_cp;
    logic [suv_pkg::MIN_W-1:0]  w_min;
    logic [LENGTH_BITS-1:0]     w_complete;
    logic [LENGTH_BITS-1:0]     w_total;
    suv_pkg::fault_t            w_fault;

    logic [LENGTH_BITS-1:0]     total_inc;
    logic                       limit_hit;
    logic                       restart;
    suv_pkg::status_t           status;
    suv_pkg::dec_t              dec;

    suv_decode u_decode (
        .pending   (work_pending_reg),
        .codepoint (work_cp_reg),
        .minimum   (work_min_reg),
        .data_byte (item.data_byte),
        .dec       (dec)
    );

    assign total_inc = work_total_reg + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    assign limit_hit = (CMP_W'(work_total_reg) >= CMP_W'(max_stream_bytes)) ||
                       (work_total_reg == {LENGTH_BITS{1'b1}});

    always_comb
    begin
        open_next           = open_reg;
        saved_pending_next  = saved_pending_reg;
        saved_cp_next       = saved_cp_reg;
        saved_min_next      = saved_min_reg;
        saved_complete_next = saved_complete_reg;
        saved_total_next    = saved_total_reg;
        work_pending_next   = work_pending_reg;
        work_cp_next        = work_cp_reg;
        work_min_next       = work_min_reg;
        work_complete_next  = work_complete_reg;
        work_total_next     = work_total_reg;
        fault_next          = fault_reg;
        restart             = 1'b0;
        res_valid           = 1'b0;
        status              = suv_pkg::ST_OK;

        w_pending  = work_pending_reg;
        w_cp       = work_cp_reg;
        w_min      = work_min_reg;
        w_complete = work_complete_reg;
        w_total    = work_total_reg;
        w_fault    = fault_reg;

        case (suv_pkg::mode_t'(item.mode))
            suv_pkg::MODE_BEGIN:
            begin
                open_next           = 1'b1;
                saved_pending_next  = '0;
                saved_cp_next       = '0;
                saved_min_next      = '0;
                saved_complete_next = '0;
                saved_total_next    = '0;
                restart             = 1'b1;
                res_valid           = 1'b1;
            end
            suv_pkg::MODE_END:
            begin
                restart   = 1'b1;
                res_valid = 1'b1;
                if (!open_reg)
                begin
                    status = suv_pkg::ST_NOT_ACTIVE;
                end
                else if (saved_pending_reg != 2'd0)
                begin
                    status = suv_pkg::ST_INCOMPLETE;
                end
                else
                begin
                    open_next = 1'b0;
                end
            end
            suv_pkg::MODE_DATA:
            begin
                if (!open_reg)
                begin
                    restart   = 1'b1;
                    res_valid = item.last_in_chunk;
                    status    = suv_pkg::ST_NOT_ACTIVE;
                end
                else
                begin
                    // Once too large, the rest of the chunk is neither decoded nor counted.
                    if (fault_reg != suv_pkg::FAULT_LARGE)
                    begin
                        if (limit_hit)
                        begin
                            w_fault = suv_pkg::FAULT_LARGE;
                        end
                        else
                        begin
                            w_total = total_inc;
                            if (fault_reg == suv_pkg::FAULT_NONE)
                            begin
                                if (dec.err)
                                begin
                                    w_fault = suv_pkg::FAULT_INVALID;
                                end
                                else
                                begin
                                    w_pending = dec.pending;
                                    w_cp      = dec.codepoint;
                                    w_min     = dec.minimum;
                                    if (dec.done)
                                    begin
                                        w_complete = total_inc;
                                    end
                                end
                            end
                        end
                    end

                    if (item.last_in_chunk)
                    begin
                        res_valid = 1'b1;
                        restart   = 1'b1;
                        if (w_fault == suv_pkg::FAULT_NONE)
                        begin
                            saved_pending_next  = w_pending;
                            saved_cp_next       = w_cp;
                            saved_min_next      = w_min;
                            saved_complete_next = w_complete;
                            saved_total_next    = w_total;
                        end
                        else if (w_fault == suv_pkg::FAULT_LARGE)
                        begin
                            status = suv_pkg::ST_TOO_LARGE;
                        end
                        else
                        begin
                            status = suv_pkg::ST_INVALID;
                        end
                    end
                    else
                    begin
                        work_pending_next  = w_pending;
                        work_cp_next       = w_cp;
                        work_min_next      = w_min;
                        work_complete_next = w_complete;
                        work_total_next    = w_total;
                        fault_next         = w_fault;
                    end
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        // A new chunk always starts from the committed state.
        if (restart)
        begin
            work_pending_next  = saved_pending_next;
            work_cp_next       = saved_cp_next;
            work_min_next      = saved_min_next;
            work_complete_next = saved_complete_next;
            work_total_next    = saved_total_next;
            fault_next         = suv_pkg::FAULT_NONE;
        end

        res.status          = status;
        res.complete_length = suv_pkg::FIELD_W'(saved_complete_next);
        res.total_length    = suv_pkg::FIELD_W'(saved_total_next);
        res.pending_bytes   = saved_pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg           <= 1'b0;
            saved_pending_reg  <= '0;
            saved_cp_reg       <= '0;
            saved_min_reg      <= '0;
            saved_complete_reg <= '0;
            saved_total_reg    <= '0;
            work_pending_reg   <= '0;
            work_cp_reg        <= '0;
            work_min_reg       <= '0;
            work_complete_reg  <= '0;
            work_total_reg     <= '0;
            fault_reg          <= suv_pkg::FAULT_NONE;
        end
        else if (advance)
        begin
            open_reg           <= open_next;
            saved_pending_reg  <= saved_pending_next;
            saved_cp_reg       <= saved_cp_next;
            saved_min_reg      <= saved_min_next;
            saved_complete_reg <= saved_complete_next;
            saved_total_reg    <= saved_total_next;
            work_pending_reg   <= work_pending_next;
            work_cp_reg        <= work_cp_next;
            work_min_reg       <= work_min_next;
            work_complete_reg  <= work_complete_next;
            work_total_reg     <= work_total_next;
            fault_reg          <= fault_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/streaming_utf8_validator_core.sv =====
// ----------------------------------------------------------------------------
// Streaming UTF-8 validator core
// Checks a chunked UTF-8 byte stream one byte per transaction and reports
// the committed lengths at each chunk end, begin and end of stream.
// ----------------------------------------------------------------------------
//  Channel  Role   Payload
//  item     sink   mode, data_byte, last_in_chunk
//  result   source status, complete_length, total_length, pending_bytes
//  cfg      sink   max_stream_bytes (always ready)
//
//  One item is taken every cycle unless the input register holds an item
//  that gives a result while the output register is full; the item waits in
//  the input register and its result then waits in the output register.
//  The state update between those two registers is combinational.
//  Reset clears the stream state and loads the size limit with 64 MiB.
//  While a result waits untaken, only an item that gives a result is held in
//  the input register; bytes inside a chunk keep flowing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module streaming_utf8_validator_core #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    suv_in_if.sink     item,
    suv_out_if.source  result,
    suv_cfg_if.sink    cfg
);

    logic                            s1_valid_reg, s1_valid_next;
    suv_pkg::item_t                  s1_item_reg;
    logic                            out_valid_reg, out_valid_next;
    suv_pkg::result_t                out_data_reg;
    logic [suv_pkg::FIELD_W-1:0]     max_reg;

    logic                            advance;
    logic                            out_free;
    logic                            res_valid;
    suv_pkg::result_t                res;

    suv_stream #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_stream (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .item             (s1_item_reg),
        .max_stream_bytes (max_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = s1_valid_reg && (!res_valid || out_free);
    assign item.ready = !s1_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    assign s1_valid_next  = item.valid ? 1'b1 : (s1_valid_reg && !advance);
    assign out_valid_next = (advance && res_valid) ? 1'b1 : (out_valid_reg && !result.ready);

    assign result.valid           = out_valid_reg;
    assign result.status          = out_data_reg.status;
    assign result.complete_length = out_data_reg.complete_length;
    assign result.total_length    = out_data_reg.total_length;
    assign result.pending_bytes   = out_data_reg.pending_bytes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_reg       <= suv_pkg::MAX_BYTES_RESET;
        end
        else
        begin
            if (item.ready)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                max_reg <= cfg.max_stream_bytes;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_item_reg.mode          <= item.mode;
            s1_item_reg.data_byte     <= item.data_byte;
            s1_item_reg.last_in_chunk <= item.last_in_chunk;
        end
        if (advance && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    // The input register only stalls behind an untaken result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |-> (out_valid_reg && !result.ready))
        else $error("input register stalled with the output register free");

    // An incomplete-at-end report always carries outstanding continuation bytes.
    a_incomplete_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == suv_pkg::ST_INCOMPLETE) |->
        (result.pending_bytes != 2'd0))
        else $error("incomplete status with no pending bytes");

    // A begin transaction reports a cleared stream.
    a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.mode == suv_pkg::MODE_BEGIN) |=>
        (result.valid && result.status == suv_pkg::ST_OK && result.total_length == 32'd0 &&
         result.complete_length == 32'd0 && result.pending_bytes == 2'd0))
        else $error("begin result does not show a cleared stream");

endmodule

`default_nettype wire

// ===== dv/streaming_utf8_validator_core_tb.sv =====
// ----------------------------------------------------------------------------
// Streaming UTF-8 validator core testbench
// Drives chunked byte streams, end and begin transactions through the item
// channel and checks every result against a cycle-free model of the
// validator. The run steps through several size limits and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module streaming_utf8_validator_core_tb;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 6;

    logic clk = 1'b0;
    logic rst_n;

    suv_in_if  in_ch ();
    suv_out_if out_ch ();
    suv_cfg_if cfg_ch ();

    streaming_utf8_validator_core #(
        .LENGTH_BITS(32)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Validator model: committed stream state and in-chunk working copy
    // ------------------------------------------------------------------
    logic [31:0]      size_limit;
    bit               is_open;
    logic [1:0]       commit_pend,     chunk_pend;
    logic [20:0]      commit_cp,       chunk_cp;
    logic [16:0]      commit_floor,    chunk_floor;
    logic [31:0]      commit_done_len, chunk_done_len;
    logic [31:0]      commit_len,      chunk_len;
    suv_pkg::fault_t  chunk_err;

    suv_pkg::item_t   stream_items[$];
    suv_pkg::result_t expected_reports[$];
    logic [7:0]       text_bytes[$];
    suv_pkg::item_t   next_item;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        hold_start;
    int unsigned hold_left;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    function automatic void rewind_chunk();
        chunk_pend     = commit_pend;
        chunk_cp       = commit_cp;
        chunk_floor    = commit_floor;
        chunk_done_len = commit_done_len;
        chunk_len      = commit_len;
        chunk_err      = suv_pkg::FAULT_NONE;
    endfunction

    function automatic void clear_stream();
        commit_pend     = '0;
        commit_cp       = '0;
        commit_floor    = '0;
        commit_done_len = '0;
        commit_len      = '0;
        rewind_chunk();
    endfunction

    function automatic void post_report(input suv_pkg::status_t s);
        suv_pkg::result_t r;
        r.status          = s;
        r.complete_length = commit_done_len;
        r.total_length    = commit_len;
        r.pending_bytes   = commit_pend;
        expected_reports.push_back(r);
    endfunction

    // Advances the partial character by one byte; returns 0 if the byte
    // breaks the encoding.
    function automatic bit byte_is_legal(input logic [7:0] b);
        if (chunk_pend == 2'd0)
        begin
            if (b <= 8'h7F)
                chunk_done_len = chunk_len;
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                chunk_pend  = 2'd1;
                chunk_cp    = {16'd0, b[4:0]};
                chunk_floor = 17'h00080;
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                chunk_pend  = 2'd2;
                chunk_cp    = {17'd0, b[3:0]};
                chunk_floor = 17'h00800;
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                chunk_pend  = 2'd3;
                chunk_cp    = {18'd0, b[2:0]};
                chunk_floor = 17'h10000;
            end
            else
                return 1'b0;
            return 1'b1;
        end
        if (b[7:6] != 2'b10)
            return 1'b0;
        chunk_cp   = {chunk_cp[14:0], b[5:0]};
        chunk_pend = chunk_pend - 2'd1;
        if (chunk_pend == 2'd0)
        begin
            if (chunk_cp < chunk_floor || chunk_cp > 21'h10FFFF ||
                (chunk_cp >= 21'h00D800 && chunk_cp <= 21'h00DFFF))
                return 1'b0;
            chunk_done_len = chunk_len;
        end
        return 1'b1;
    endfunction

    function automatic void model_item(input logic [1:0] m, input logic [7:0] b,
                                       input logic last);
        if (m == suv_pkg::MODE_BEGIN)
        begin
            clear_stream();
            is_open = 1'b1;
            post_report(suv_pkg::ST_OK);
        end
        else if (m == suv_pkg::MODE_END)
        begin
            rewind_chunk();
            if (!is_open)
                post_report(suv_pkg::ST_NOT_ACTIVE);
            else if (commit_pend != 2'd0)
                post_report(suv_pkg::ST_INCOMPLETE);
            else
            begin
                is_open = 1'b0;
                post_report(suv_pkg::ST_OK);
            end
        end
        else if (m == suv_pkg::MODE_DATA)
        begin
            if (!is_open)
            begin
                rewind_chunk();
                if (last)
                    post_report(suv_pkg::ST_NOT_ACTIVE);
            end
            else
            begin
                // Once too large, the rest of the chunk is neither decoded nor
                // counted; after an invalid byte counting still goes on.
                if (chunk_err != suv_pkg::FAULT_LARGE)
                begin
                    if (chunk_len >= size_limit || chunk_len == 32'hFFFF_FFFF)
                        chunk_err = suv_pkg::FAULT_LARGE;
                    else
                    begin
                        chunk_len = chunk_len + 32'd1;
                        if (chunk_err == suv_pkg::FAULT_NONE && !byte_is_legal(b))
                            chunk_err = suv_pkg::FAULT_INVALID;
                    end
                end
                if (last)
                begin
                    if (chunk_err == suv_pkg::FAULT_NONE)
                    begin
                        commit_pend     = chunk_pend;
                        commit_cp       = chunk_cp;
                        commit_floor    = chunk_floor;
                        commit_done_len = chunk_done_len;
                        commit_len      = chunk_len;
                        post_report(suv_pkg::ST_OK);
                    end
                    else if (chunk_err == suv_pkg::FAULT_LARGE)
                        post_report(suv_pkg::ST_TOO_LARGE);
                    else
                        post_report(suv_pkg::ST_INVALID);
                    rewind_chunk();
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver and monitor
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid         <= 1'b0;
            in_ch.mode          <= suv_pkg::MODE_DATA;
            in_ch.data_byte     <= 8'd0;
            in_ch.last_in_chunk <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                model_item(in_ch.mode, in_ch.data_byte, in_ch.last_in_chunk);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (stream_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = stream_items.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.mode          <= next_item.mode;
                    in_ch.data_byte     <= next_item.data_byte;
                    in_ch.last_in_chunk <= next_item.last_in_chunk;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    function automatic void check_report();
        suv_pkg::result_t want;
        if (expected_reports.size() == 0)
        begin
            $error("unexpected result transaction: status %0d total_length %0d",
                   out_ch.status, out_ch.total_length);
            fail_count++;
            return;
        end
        want = expected_reports.pop_front();
        if (out_ch.status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, out_ch.status);
            fail_count++;
        end
        if (out_ch.complete_length !== want.complete_length)
        begin
            $error("complete_length: expected %0d, actual %0d",
                   want.complete_length, out_ch.complete_length);
            fail_count++;
        end
        if (out_ch.total_length !== want.total_length)
        begin
            $error("total_length: expected %0d, actual %0d",
                   want.total_length, out_ch.total_length);
            fail_count++;
        end
        if (out_ch.pending_bytes !== want.pending_bytes)
        begin
            $error("pending_bytes: expected %0d, actual %0d",
                   want.pending_bytes, out_ch.pending_bytes);
            fail_count++;
        end
    endfunction

    // Counts down the long receiver hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_report();
            out_ch.ready <= !hold_start && hold_left == 0 &&
                            $urandom_range(99) >= recv_idle_pct;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void put_item(input logic [1:0] m, input logic [7:0] b,
                                     input logic last);
        suv_pkg::item_t it;
        it.mode          = m;
        it.data_byte     = b;
        it.last_in_chunk = last;
        stream_items.push_back(it);
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    function automatic logic [20:0] pick_codepoint();
        case ($urandom_range(5))
            0: return 21'($urandom_range(32'h7F));
            1: return 21'($urandom_range(32'h7FF, 32'h80));
            2: return 21'($urandom_range(32'hD7FF, 32'h800));
            3: return 21'($urandom_range(32'hFFFF, 32'hE000));
            4: return 21'($urandom_range(32'h10FFFF, 32'h10000));
            default:
                case ($urandom_range(9))
                    0: return 21'h0;
                    1: return 21'h7F;
                    2: return 21'h80;
                    3: return 21'h7FF;
                    4: return 21'h800;
                    5: return 21'hD7FF;
                    6: return 21'hE000;
                    7: return 21'hFFFF;
                    8: return 21'h10000;
                    default: return 21'h10FFFF;
                endcase
        endcase
    endfunction

    function automatic void add_char(input logic [20:0] cp);
        if (cp < 21'h80)
            text_bytes.push_back(cp[7:0]);
        else if (cp < 21'h800)
        begin
            text_bytes.push_back({3'b110, cp[10:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            text_bytes.push_back({4'b1110, cp[15:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            text_bytes.push_back({5'b11110, cp[20:18]});
            text_bytes.push_back({2'b10, cp[17:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    // Overlong forms, surrogates, values past the top of the code space,
    // stray continuations and truncated characters.
    function automatic void add_bad_sequence();
        case ($urandom_range(7))
            0:
            begin
                text_bytes.push_back(8'($urandom_range(8'hC1, 8'hC0)));
                text_bytes.push_back(cont_byte());
            end
            1: text_bytes.push_back(8'($urandom_range(8'hFF, 8'hF5)));
            2: text_bytes.push_back(cont_byte());
            3:
            begin
                text_bytes.push_back(8'hE0);
                text_bytes.push_back(8'($urandom_range(8'h9F, 8'h80)));
                text_bytes.push_back(cont_byte());
            end
            4:
            begin
                text_bytes.push_back(8'hED);
                text_bytes.push_back(8'($urandom_range(8'hBF, 8'hA0)));
                text_bytes.push_back(cont_byte());
            end
            5:
            begin
                text_bytes.push_back(8'hF0);
                text_bytes.push_back(8'($urandom_range(8'h8F, 8'h80)));
                text_bytes.push_back(cont_byte());
                text_bytes.push_back(cont_byte());
            end
            6:
            begin
                text_bytes.push_back(8'hF4);
                text_bytes.push_back(8'($urandom_range(8'hBF, 8'h90)));
                text_bytes.push_back(cont_byte());
                text_bytes.push_back(cont_byte());
            end
            default:
            begin
                text_bytes.push_back(8'($urandom_range(8'hF4, 8'hC2)));
                text_bytes.push_back(8'($urandom_range(8'h7F)));
            end
        endcase
    endfunction

    // One stream: begin, the text cut into random chunks, then mostly an end.
    function automatic void queue_stream(input bit corrupt);
        int nchars;
        int bad_at;
        int pos;
        int len;
        int j;
        bit final_open;
        text_bytes.delete();
        nchars = $urandom_range(10, 1);
        bad_at = corrupt ? $urandom_range(nchars) : -1;
        for (int i = 0; i <= nchars; i++)
        begin
            if (i == bad_at)
                add_bad_sequence();
            if (i < nchars)
                add_char(pick_codepoint());
        end
        final_open = ($urandom_range(9) == 0);
        put_item(suv_pkg::MODE_BEGIN, 8'($urandom_range(255)), 1'($urandom_range(1)));
        pos = 0;
        while (pos < text_bytes.size())
        begin
            len = $urandom_range(6, 1);
            for (j = 0; j < len && pos < text_bytes.size(); j++)
            begin
                if (pos == text_bytes.size() - 1)
                    put_item(suv_pkg::MODE_DATA, text_bytes[pos], !final_open);
                else
                    put_item(suv_pkg::MODE_DATA, text_bytes[pos], j == len - 1);
                pos++;
            end
            // An early end may find a character split across chunks.
            if ($urandom_range(19) == 0)
                put_item(suv_pkg::MODE_END, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        if ($urandom_range(9) != 0)
            put_item(suv_pkg::MODE_END, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endfunction

    function automatic void queue_noise(input int n);
        for (int i = 0; i < n; i++)
            put_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                     1'($urandom_range(1)));
    endfunction

    function automatic void queue_random_traffic(input int count);
        int start;
        int roll;
        start = stream_items.size();
        while (stream_items.size() - start < count)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
                queue_stream(1'b0);
            else if (roll < 85)
                queue_stream(1'b1);
            else
                queue_noise($urandom_range(6, 1));
        end
    endfunction

    function automatic void queue_directed();
        put_item(suv_pkg::MODE_DATA,  8'h41, 1'b1);    // byte while the stream is closed
        put_item(suv_pkg::MODE_END,   8'hFF, 1'b1);    // end while closed
        put_item(MODE_UNUSED,         8'h00, 1'b1);    // ignored entirely
        put_item(suv_pkg::MODE_BEGIN, 8'h00, 1'b0);
        put_item(suv_pkg::MODE_DATA,  8'h00, 1'b0);
        put_item(suv_pkg::MODE_DATA,  8'h7F, 1'b1);
        put_item(suv_pkg::MODE_DATA,  8'hC2, 1'b0);
        put_item(suv_pkg::MODE_DATA,  8'h80, 1'b0);
        put_item(suv_pkg::MODE_DATA,  8'hE0, 1'b1);    // character left open at chunk end
        put_item(suv_pkg::MODE_END,   8'h00, 1'b0);    // incomplete, stream stays open
        put_item(suv_pkg::MODE_DATA,  8'hA0, 1'b0);
        put_item(suv_pkg::MODE_DATA,  8'h80, 1'b1);
        put_item(suv_pkg::MODE_DATA,  8'hF4, 1'b0);    // highest code point
        put_item(suv_pkg::MODE_DATA,  8'h8F, 1'b0);
        put_item(suv_pkg::MODE_DATA,  8'hBF, 1'b0);
        put_item(suv_pkg::MODE_DATA,  8'hBF, 1'b1);
        put_item(suv_pkg::MODE_DATA,  8'hF4, 1'b0);    // starts a value beyond the code space, left open
        put_item(suv_pkg::MODE_DATA,  8'h90, 1'b1);
        put_item(suv_pkg::MODE_DATA,  8'hED, 1'b0);    // surrogate lead, rejected as no continuation
        put_item(suv_pkg::MODE_DATA,  8'hA0, 1'b1);
        put_item(suv_pkg::MODE_DATA,  8'hFF, 1'b1);
        put_item(suv_pkg::MODE_DATA,  8'h41, 1'b0);    // chunk dropped by the begin below
        put_item(suv_pkg::MODE_BEGIN, 8'hFF, 1'b1);
        put_item(suv_pkg::MODE_END,   8'h00, 1'b0);
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (stream_items.size() != 0 || in_ch.valid || expected_reports.size() != 0);
        // Bytes inside a chunk give no result and may still be in the pipeline.
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        @(posedge clk);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.max_stream_bytes <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        size_limit = v;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] limit, input int count);
        write_limit(limit);
        @(negedge clk);
        queue_random_traffic(count);
        wait_drained();
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.max_stream_bytes = 32'd0;
        hold_start              = 1'b0;
        send_idle_pct           = 33;
        recv_idle_pct           = 78;
        size_limit              = suv_pkg::MAX_BYTES_RESET;
        is_open                 = 1'b0;
        clear_stream();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        queue_directed();
        wait_drained();

        // Long receiver hold-off while the sender keeps offering transactions.
        write_limit(32'hFFFF_FFFF);
        @(negedge clk);
        queue_random_traffic(300);
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        wait_drained();

        run_phase(32'd0, 100);

        send_idle_pct <= 78;
        recv_idle_pct <= 33;
        run_phase(32'($urandom_range(40, 8)), 300);
        run_phase(32'd1, 100);

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        run_phase(32'($urandom_range(120, 40)), 300);
        run_phase(suv_pkg::MAX_BYTES_RESET, 250);
        run_phase(32'hFFFF_FFFE, 300);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
